// File: rtl/mws_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the mecanum wheel speed solver.
// No dependencies.
package mws_pkg;

  localparam int RotStagesDef = 16;
  localparam int AtanEntries  = 24;
  localparam logic signed [31:0] CordicGainQ30 = 32'sd652032874;

  localparam logic [1:0] REG_HALF_LENGTH    = 2'd0;
  localparam logic [1:0] REG_HALF_WIDTH     = 2'd1;
  localparam logic [1:0] REG_GIMBAL_OFFSET  = 2'd2;
  localparam logic [1:0] REG_INVERSE_RADIUS = 2'd3;

  // one item as it moves down the rotation chain
  typedef struct packed {
    logic               valid;
    logic signed [23:0] fwd;
    logic signed [23:0] side;
    logic signed [23:0] turn;
    logic               flip;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [33:0] z;
  } mws_cell_t;

  typedef struct packed {
    logic        [15:0] half_length;
    logic        [15:0] half_width;
    logic signed [15:0] gimbal_offset;
    logic        [15:0] inverse_radius;
  } mws_cfg_t;

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/mws_cordic_cell.sv
`timescale 1ns / 1ps
// One CORDIC rotation cell: a single micro-rotation, registered.
// Depends on mws_pkg.
module mws_cordic_cell import mws_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  mws_cell_t cell_in,
  output mws_cell_t cell_out
);

  localparam logic [4:0] StageIdx = 5'(STAGE);

  mws_cell_t cell_r, cell_nxt;
  logic signed [31:0] dx, dy;
  logic signed [33:0] ang;

  always_comb begin
    dx  = cell_in.y >>> STAGE;
    dy  = cell_in.x >>> STAGE;
    ang = signed'({2'b00, atan_turns(StageIdx)});
    cell_nxt = cell_in;
    if (!cell_in.z[33]) begin
      cell_nxt.x = cell_in.x - dx;
      cell_nxt.y = cell_in.y + dy;
      cell_nxt.z = cell_in.z - ang;
    end else begin
      cell_nxt.x = cell_in.x + dx;
      cell_nxt.y = cell_in.y - dy;
      cell_nxt.z = cell_in.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r.valid <= cell_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r.fwd  <= cell_nxt.fwd;
      cell_r.side <= cell_nxt.side;
      cell_r.turn <= cell_nxt.turn;
      cell_r.flip <= cell_nxt.flip;
      cell_r.x    <= cell_nxt.x;
      cell_r.y    <= cell_nxt.y;
      cell_r.z    <= cell_nxt.z;
    end
  end

  assign cell_out = cell_r;

endmodule

// File: rtl/mws_wheel_mix.sv
`timescale 1ns / 1ps
// Wheel mixing: frame rotation products, lever terms, radius scaling,
// rounding and saturation, then the output register. Depends on mws_pkg.
module mws_wheel_mix import mws_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  mws_cell_t          cell_in,
  input  mws_cfg_t           cfg,
  output logic               out_valid,
  output logic signed [31:0] out_left_front,
  output logic signed [31:0] out_right_front,
  output logic signed [31:0] out_right_rear,
  output logic signed [31:0] out_left_rear
);

  function automatic logic signed [31:0] finish(input logic signed [61:0] p,
                                                input logic neg);
    logic signed [61:0] rnd;
    logic signed [62:0] r;
    rnd = (p + 62'sd8388608) >>> 24;
    r   = neg ? -63'(rnd) : 63'(rnd);
    if (r > 63'sd2147483647)       return 32'sh7fffffff;
    else if (r < -63'sd2147483648) return 32'sh80000000;
    else                           return r[31:0];
  endfunction

  // stage 1: products
  logic        v1_r;
  logic signed [31:0] cs, sn;
  logic signed [55:0] fx_r, sy_r, sx_r, fy_r;
  // lever arms reach 2*65535 + 32768, so they need 19 bits signed
  logic signed [18:0] arm_f, arm_r;
  logic signed [42:0] lf_r, lr_r;
  // stage 2: wheel sums
  logic        v2_r;
  logic signed [42:0] vx, vy;
  logic signed [44:0] s_r [4];
  // stage 3: radius scaling
  logic        v3_r;
  logic signed [61:0] p_r [4];
  // output
  logic        ov_r;
  logic signed [31:0] o_r [4];

  always_comb begin
    cs = cell_in.flip ? -cell_in.x : cell_in.x;
    sn = cell_in.flip ? -cell_in.y : cell_in.y;
    arm_f = 19'(cfg.half_length) + 19'(cfg.half_width) - 19'(cfg.gimbal_offset);
    arm_r = 19'(cfg.half_length) + 19'(cfg.half_width) + 19'(cfg.gimbal_offset);
    vx = 43'((57'(fx_r) + 57'(sy_r) + 57'sd8192) >>> 14);
    vy = 43'((57'(sx_r) - 57'(fy_r) + 57'sd8192) >>> 14);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      v1_r <= cell_in.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      ov_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx_r <= cell_in.fwd * cs;
      sy_r <= cell_in.side * sn;
      sx_r <= cell_in.side * cs;
      fy_r <= cell_in.fwd * sn;
      lf_r <= arm_f * cell_in.turn;
      lr_r <= arm_r * cell_in.turn;
      s_r[0] <= 45'(vx) + 45'(vy) - 45'(lf_r);
      s_r[1] <= 45'(vx) - 45'(vy) + 45'(lf_r);
      s_r[2] <= 45'(vx) + 45'(vy) + 45'(lr_r);
      s_r[3] <= 45'(vx) - 45'(vy) - 45'(lr_r);
      for (int k = 0; k < 4; k++) begin
        p_r[k] <= s_r[k] * signed'({1'b0, cfg.inverse_radius});
      end
      o_r[0] <= finish(p_r[0], 1'b0);
      o_r[1] <= finish(p_r[1], 1'b1);
      o_r[2] <= finish(p_r[2], 1'b1);
      o_r[3] <= finish(p_r[3], 1'b0);
    end
  end

  assign out_valid       = ov_r;
  assign out_left_front  = o_r[0];
  assign out_right_front = o_r[1];
  assign out_right_rear  = o_r[2];
  assign out_left_rear   = o_r[3];

endmodule

// File: rtl/mecanum_wheel_speed_solver_core.sv
`timescale 1ns / 1ps
// Top level of the mecanum wheel speed solver.
// Depends on mws_pkg, mws_cordic_cell and mws_wheel_mix.

// Takes one command per clock and returns four saturated Q16.16 wheel
// speeds (right wheels negated). The heading rotation runs through a
// chain of ROTATION_STAGES CORDIC cells, followed by three mixing stages
// and the output register. The whole pipeline holds while a result waits
// at the output; otherwise an item enters every cycle. Registers sit at
// byte addresses 0, 4, 8 and 12 and must only be written while no item
// is in flight.
module mecanum_wheel_speed_solver_core import mws_pkg::*; #(
  parameter int ROTATION_STAGES = RotStagesDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_forward_speed,
  input  logic signed [23:0] in_side_speed,
  input  logic signed [23:0] in_turn_rate,
  input  logic signed [15:0] in_heading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_left_front,
  output logic signed [31:0] out_right_front,
  output logic signed [31:0] out_right_rear,
  output logic signed [31:0] out_left_rear,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  mws_cfg_t  cfg_r;
  mws_cell_t chain [ROTATION_STAGES+1];
  logic      en;
  logic      flip;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_HALF_LENGTH:    cfg_r.half_length    <= pwdata[15:0];
        REG_HALF_WIDTH:     cfg_r.half_width     <= pwdata[15:0];
        REG_GIMBAL_OFFSET:  cfg_r.gimbal_offset  <= pwdata[15:0];
        REG_INVERSE_RADIUS: cfg_r.inverse_radius <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_HALF_LENGTH:    prdata = {16'd0, cfg_r.half_length};
      REG_HALF_WIDTH:     prdata = {16'd0, cfg_r.half_width};
      REG_GIMBAL_OFFSET:  prdata = {16'd0, cfg_r.gimbal_offset};
      REG_INVERSE_RADIUS: prdata = {16'd0, cfg_r.inverse_radius};
      default:            prdata = '0;
    endcase
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // headings beyond +-pi/2 are turned by pi, and the result negated later
  assign flip = in_heading[15] ^ in_heading[14];

  always_comb begin
    chain[0].valid = in_valid;
    chain[0].fwd   = in_forward_speed;
    chain[0].side  = in_side_speed;
    chain[0].turn  = in_turn_rate;
    chain[0].flip  = flip;
    chain[0].x     = CordicGainQ30;
    chain[0].y     = '0;
    chain[0].z     = 34'(signed'({in_heading[15] ^ flip, in_heading[14:0], 16'd0}));
  end

  for (genvar g = 0; g < ROTATION_STAGES; g++) begin : g_cell
    mws_cordic_cell #(.STAGE(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cell_in  (chain[g]),
      .cell_out (chain[g+1])
    );
  end

  mws_wheel_mix u_mix (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .cell_in         (chain[ROTATION_STAGES]),
    .cfg             (cfg_r),
    .out_valid       (out_valid),
    .out_left_front  (out_left_front),
    .out_right_front (out_right_front),
    .out_right_rear  (out_right_rear),
    .out_left_rear   (out_left_rear)
  );

endmodule

// File: rtl/mws_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the solver core, bound to the top level.
// Depends on mecanum_wheel_speed_solver_core.
module mws_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_left_front,
  input logic signed [31:0] out_left_rear
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_front)
      && $stable(out_left_rear))
    else $error("result changed while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind mecanum_wheel_speed_solver_core mws_checker u_mws_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_left_front (out_left_front),
  .out_left_rear  (out_left_rear)
);
